>>> hdl/mrse_pkg.sv
// Shared types, codes and widths of the monotone rational spline evaluator.
`default_nettype none

package mrse_pkg;

    // Fixed-point format of every knot word
    localparam int WORD_BITS     = 32;
    localparam int FRAC_BITS     = 16;
    localparam int DEF_MAX_KNOTS = 64;

    // Root operand is a slope scaled by the fraction bits
    localparam int SQ_BITS   = WORD_BITS + FRAC_BITS;
    localparam int ROOT_BITS = SQ_BITS / 2;

    // Item kinds
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_EVAL   = 2'd2;

    // Result status codes
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_PARAM_ORD = 3'd1;
    localparam logic [2:0] STAT_VALUE_ORD = 3'd2;
    localparam logic [2:0] STAT_SLOPE_NEG = 3'd3;
    localparam logic [2:0] STAT_FULL      = 3'd4;
    localparam logic [2:0] STAT_RANGE     = 3'd5;
    localparam logic [2:0] STAT_FEW       = 3'd6;

    // Configuration register indexes
    localparam logic [0:0] CFG_RANGE_TOL = 1'b0;
    localparam logic [0:0] CFG_EQUAL_TOL = 1'b1;

    localparam logic signed [WORD_BITS-1:0] SLOPE_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};

    typedef struct packed {
        logic signed [WORD_BITS-1:0] param;
        logic signed [WORD_BITS-1:0] value;
        logic signed [WORD_BITS-1:0] slope;
    } knot_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_SRCH_WAIT,
        S_SEG_LO,
        S_SEG_HI,
        S_PREP,
        S_SQRT,
        S_LAUNCH,
        S_MUL,
        S_DIV,
        S_STORE,
        S_FIN
    } state_t;

    // Arithmetic program steps of one evaluation
    typedef enum logic [3:0] {
        ST_PBS,
        ST_TH,
        ST_DW,
        ST_X,
        ST_Y,
        ST_M,
        ST_R,
        ST_NB,
        ST_BLEND,
        ST_MQ,
        ST_MM,
        ST_P
    } step_t;

endpackage

`default_nettype wire

>>> hdl/monotone_rational_spline_eval_unit.sv
// Top level: knot table memory, search sequencer and serial blend arithmetic.
//
//  channel | signals                                   | dir | handshake
//  --------+-------------------------------------------+-----+---------------------
//  in      | kind, knot_param, knot_value, knot_slope  | in  | in_valid / in_ready
//  out     | status, out_param, out_value, out_slope   | out | out_valid / out_ready
//  cfg     | cfg_index, cfg_data                       | in  | cfg_wr_en, no wait
//
// Clear, append, refused or ignored items pass from the idle state through the
// finish state to the output register. An evaluation searches the n knots, then
// runs the root unit (one digit a cycle) if the slopes differ, and the restoring
// divider (one quotient bit a cycle); a query at a knot ends after the search.
// One item is in work at a time; the next is taken while a result waits.
// Reset clears the knot count and sets both tolerances to 1; the table is not
// cleared, entries at or above the count are never read.
`default_nettype none

module monotone_rational_spline_eval_unit #(
    parameter int MAX_KNOTS = mrse_pkg::DEF_MAX_KNOTS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic signed [31:0] knot_param,
    input  logic signed [31:0] knot_value,
    input  logic signed [31:0] knot_slope,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic signed [31:0] out_param,
    output logic signed [31:0] out_value,
    output logic signed [31:0] out_slope,
    input  logic               cfg_wr_en,
    input  logic [0:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int AW  = $clog2(MAX_KNOTS);
    localparam int CW  = $clog2(MAX_KNOTS + 1);
    localparam int SH  = mrse_pkg::FRAC_BITS + 1;
    localparam int SQW = mrse_pkg::SQ_BITS;
    localparam int RW  = mrse_pkg::ROOT_BITS;

    // Control registers
    mrse_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    count_reg;
    logic             out_valid_reg;
    logic [15:0]      range_tol_reg;
    logic [15:0]      equal_tol_reg;

    // Knot memory
    mrse_pkg::knot_t  mem [MAX_KNOTS];
    mrse_pkg::knot_t  rd_data_reg;
    mrse_pkg::knot_t  mem_wdata;
    logic [AW-1:0]    mem_addr;
    logic             mem_we;

    // Datapath registers
    logic signed [31:0] first_param_reg, last_param_reg, last_value_reg, x_reg;
    logic [CW-1:0]      lo_reg, hi_reg, mid_reg;
    logic [AW-1:0]      li_reg;
    mrse_pkg::knot_t    lower_reg, upper_knot_reg;
    logic               upper_reg;
    logic [31:0]        pb_reg, h2_reg, t2_reg, dy_reg;
    logic [RW-1:0]      wl_reg, wu_reg;
    logic [SQW-1:0]     sq_v_reg, sq_res_reg, sq_bit_reg;
    logic               sq_second_reg;
    mrse_pkg::step_t    step_reg;
    logic [95:0]        mul_a_reg;
    logic [63:0]        mul_b_reg;
    logic [1:0]         mul_i_reg, mul_ni_reg;
    logic               mul_j_reg, mul_nj_reg;
    logic [63:0]        pp_reg;
    logic [1:0]         pp_sh_reg;
    logic [127:0]       acc_reg;
    logic [128:0]       div_rem_reg;
    logic [47:0]        div_low_reg, div_q_reg;
    logic [127:0]       div_d_reg;
    logic [5:0]         div_cnt_reg, div_last_reg;
    logic [55:0]        pbs_reg, dw_reg;
    logic [63:0]        th_reg;
    logic [127:0]       xp_reg, z_reg, mnum_reg, nb_reg;
    logic [32:0]        r_reg;
    logic [47:0]        m_reg;
    logic [95:0]        mm_reg;
    logic [2:0]         res_status;
    logic signed [31:0] res_param, res_value, res_slope;
    logic [2:0]         status_reg;
    logic signed [31:0] out_param_reg, out_value_reg, out_slope_reg;

    // Item decode
    logic accept, fin_go;
    logic [2:0] append_status, eval_status;
    logic signed [33:0] q_ext, first_ext, last_ext, tol_ext;
    logic signed [31:0] x_clamp;

    assign accept = in_valid & in_ready;
    assign fin_go = !out_valid_reg || out_ready;

    always_comb
    begin
        if (count_reg != '0 && knot_param <= last_param_reg)
            append_status = mrse_pkg::STAT_PARAM_ORD;
        else if (count_reg != '0 && knot_value <= last_value_reg)
            append_status = mrse_pkg::STAT_VALUE_ORD;
        else if (knot_slope <= 32'sd0)
            append_status = mrse_pkg::STAT_SLOPE_NEG;
        else if (count_reg >= CW'(MAX_KNOTS))
            append_status = mrse_pkg::STAT_FULL;
        else
            append_status = mrse_pkg::STAT_OK;
    end

    // Range check against the widened knot span, then clamp
    assign q_ext     = knot_param;
    assign first_ext = first_param_reg;
    assign last_ext  = last_param_reg;
    assign tol_ext   = {18'b0, range_tol_reg};

    always_comb
    begin
        if (count_reg < CW'(2))
            eval_status = mrse_pkg::STAT_FEW;
        else if (q_ext < first_ext - tol_ext || q_ext > last_ext + tol_ext)
            eval_status = mrse_pkg::STAT_RANGE;
        else
            eval_status = mrse_pkg::STAT_OK;
    end

    assign x_clamp = (knot_param < first_param_reg) ? first_param_reg :
                     (knot_param > last_param_reg) ? last_param_reg : knot_param;

    // Binary search step
    logic          lo_lt_hi;
    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid, li_full, n_m2;

    assign lo_lt_hi = lo_reg < hi_reg;
    assign mid_sum  = (CW+1)'(lo_reg) + (CW+1)'(hi_reg);
    assign mid      = mid_sum[CW:1];
    assign n_m2     = count_reg - CW'(2);

    always_comb
    begin
        li_full = (lo_reg == '0) ? '0 : lo_reg - CW'(1);
        if (li_full > n_m2)
            li_full = n_m2;
    end

    // Segment preparation
    logic signed [32:0] ends_sum, two_x, dx, span, dslope;
    logic [32:0]        dx_abs, dslope_abs;
    logic               pre_upper, near_base, slopes_equal;
    mrse_pkg::knot_t    base_knot;

    assign ends_sum     = 33'(lower_reg.param) + 33'(upper_knot_reg.param);
    assign two_x        = $signed({x_reg, 1'b0});
    assign pre_upper    = two_x >= ends_sum;
    assign base_knot    = pre_upper ? upper_knot_reg : lower_reg;
    assign dx           = 33'(x_reg) - 33'(base_knot.param);
    assign dx_abs       = dx[32] ? -dx : dx;
    assign near_base    = dx_abs < 33'(equal_tol_reg);
    assign span         = 33'(upper_knot_reg.param) - 33'(lower_reg.param);
    assign dslope       = 33'(lower_reg.slope) - 33'(upper_knot_reg.slope);
    assign dslope_abs   = dslope[32] ? -dslope : dslope;
    assign slopes_equal = dslope_abs < 33'(equal_tol_reg);

    // Blend weights
    logic [RW:0]   s_sum;
    logic [RW-1:0] w_sel;

    assign s_sum = (RW+1)'(wl_reg) + (RW+1)'(wu_reg);
    assign w_sel = upper_reg ? wu_reg : wl_reg;

    // Root digit step
    logic [SQW-1:0] sq_t, sq_v_next, sq_res_next;
    logic           sq_ge;

    assign sq_t        = sq_res_reg + sq_bit_reg;
    assign sq_ge       = sq_v_reg >= sq_t;
    assign sq_v_next   = sq_ge ? sq_v_reg - sq_t : sq_v_reg;
    assign sq_res_next = sq_ge ? (sq_res_reg >> 1) + sq_bit_reg : sq_res_reg >> 1;

    // Multiplier partial product and accumulate
    logic [31:0]  a_chunk, b_chunk;
    logic [127:0] pp_shifted, acc_sum;
    logic         mul_last;

    always_comb
    begin
        case (mul_i_reg)
            2'd0:    a_chunk = mul_a_reg[31:0];
            2'd1:    a_chunk = mul_a_reg[63:32];
            default: a_chunk = mul_a_reg[95:64];
        endcase
        b_chunk = mul_j_reg ? mul_b_reg[63:32] : mul_b_reg[31:0];
        case (pp_sh_reg)
            2'd0:    pp_shifted = {64'b0, pp_reg};
            2'd1:    pp_shifted = {32'b0, pp_reg, 32'b0};
            2'd2:    pp_shifted = {pp_reg, 64'b0};
            default: pp_shifted = {pp_reg[31:0], 96'b0};
        endcase
    end

    assign acc_sum  = acc_reg + pp_shifted;
    assign mul_last = (mul_i_reg == mul_ni_reg) && (mul_j_reg == mul_nj_reg);

    // Restoring divider step
    logic [128:0] div_shift, div_rem_next;
    logic         div_ge, step_is_div, mq_ovf;

    assign div_shift    = {div_rem_reg[127:0], div_low_reg[47]};
    assign div_ge       = div_shift >= {1'b0, div_d_reg};
    assign div_rem_next = div_ge ? div_shift - {1'b0, div_d_reg} : div_shift;
    assign step_is_div  = (step_reg == mrse_pkg::ST_R) || (step_reg == mrse_pkg::ST_BLEND)
                          || (step_reg == mrse_pkg::ST_MQ);
    // Slope ratio of 2^16 or more saturates
    assign mq_ovf       = (mnum_reg >> 16) >= z_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mrse_pkg::S_IDLE:
                if (accept)
                    state_next = (kind == mrse_pkg::KIND_EVAL && eval_status == mrse_pkg::STAT_OK)
                                 ? mrse_pkg::S_SRCH : mrse_pkg::S_FIN;
            mrse_pkg::S_SRCH:
                state_next = lo_lt_hi ? mrse_pkg::S_SRCH_WAIT : mrse_pkg::S_SEG_LO;
            mrse_pkg::S_SRCH_WAIT:
                state_next = mrse_pkg::S_SRCH;
            mrse_pkg::S_SEG_LO:
                state_next = mrse_pkg::S_SEG_HI;
            mrse_pkg::S_SEG_HI:
                state_next = mrse_pkg::S_PREP;
            mrse_pkg::S_PREP:
                if (near_base)
                    state_next = mrse_pkg::S_FIN;
                else if (slopes_equal)
                    state_next = mrse_pkg::S_LAUNCH;
                else
                    state_next = mrse_pkg::S_SQRT;
            mrse_pkg::S_SQRT:
                if (sq_bit_reg[0] && sq_second_reg)
                    state_next = mrse_pkg::S_LAUNCH;
            mrse_pkg::S_LAUNCH:
                if (!step_is_div)
                    state_next = mrse_pkg::S_MUL;
                else if (step_reg == mrse_pkg::ST_MQ && mq_ovf)
                    state_next = mrse_pkg::S_FIN;
                else
                    state_next = mrse_pkg::S_DIV;
            mrse_pkg::S_MUL:
                if (mul_last)
                    state_next = mrse_pkg::S_STORE;
            mrse_pkg::S_DIV:
                if (div_cnt_reg == div_last_reg)
                    state_next = mrse_pkg::S_STORE;
            mrse_pkg::S_STORE:
                state_next = (step_reg == mrse_pkg::ST_P) ? mrse_pkg::S_FIN : mrse_pkg::S_LAUNCH;
            mrse_pkg::S_FIN:
                if (fin_go)
                    state_next = mrse_pkg::S_IDLE;
            default:
                state_next = mrse_pkg::S_IDLE;
        endcase
    end

    // State outputs: handshake and memory port
    always_comb
    begin
        in_ready  = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = count_reg[AW-1:0];
        mem_wdata = '{param: knot_param, value: knot_value, slope: knot_slope};
        unique case (state_reg)
            mrse_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                mem_we   = accept && kind == mrse_pkg::KIND_APPEND
                           && append_status == mrse_pkg::STAT_OK;
            end
            mrse_pkg::S_SRCH:
                mem_addr = lo_lt_hi ? mid[AW-1:0] : li_full[AW-1:0];
            mrse_pkg::S_SEG_LO:
                mem_addr = li_reg + AW'(1);
            default:
                mem_addr = count_reg[AW-1:0];
        endcase
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_param = out_param_reg;
    assign out_value = out_value_reg;
    assign out_slope = out_slope_reg;

    // Knot table with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rd_data_reg <= mem[mem_addr];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mrse_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            range_tol_reg <= 16'd1;
            equal_tol_reg <= 16'd1;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && kind == mrse_pkg::KIND_CLEAR)
                count_reg <= '0;
            else if (mem_we)
                count_reg <= count_reg + CW'(1);
            if (state_reg == mrse_pkg::S_FIN && fin_go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    mrse_pkg::CFG_RANGE_TOL: range_tol_reg <= cfg_data;
                    mrse_pkg::CFG_EQUAL_TOL: equal_tol_reg <= cfg_data;
                    default:                 range_tol_reg <= range_tol_reg;
                endcase
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            mrse_pkg::S_IDLE:
            if (accept)
            begin
                res_param  <= '0;
                res_value  <= '0;
                res_slope  <= '0;
                res_status <= mrse_pkg::STAT_OK;
                x_reg      <= x_clamp;
                lo_reg     <= '0;
                hi_reg     <= count_reg;
                step_reg   <= mrse_pkg::ST_PBS;
                case (kind)
                    mrse_pkg::KIND_APPEND:
                    begin
                        res_status <= append_status;
                        if (mem_we)
                        begin
                            last_param_reg <= knot_param;
                            last_value_reg <= knot_value;
                            if (count_reg == '0)
                                first_param_reg <= knot_param;
                        end
                    end
                    mrse_pkg::KIND_EVAL:
                        res_status <= eval_status;
                    default:
                        res_status <= mrse_pkg::STAT_OK;
                endcase
            end

            mrse_pkg::S_SRCH:
            begin
                mid_reg <= mid;
                li_reg  <= li_full[AW-1:0];
            end

            mrse_pkg::S_SRCH_WAIT:
                if (rd_data_reg.param < x_reg)
                    lo_reg <= mid_reg + CW'(1);
                else
                    hi_reg <= mid_reg;

            mrse_pkg::S_SEG_LO:
                lower_reg <= rd_data_reg;

            mrse_pkg::S_SEG_HI:
                upper_knot_reg <= rd_data_reg;

            mrse_pkg::S_PREP:
            begin
                upper_reg <= pre_upper;
                pb_reg    <= base_knot.slope;
                h2_reg    <= span[31:0];
                t2_reg    <= {dx_abs[30:0], 1'b0};
                dy_reg    <= upper_knot_reg.value - lower_reg.value;
                if (near_base)
                begin
                    res_param <= base_knot.param;
                    res_value <= base_knot.value;
                    res_slope <= base_knot.slope;
                end
                else if (slopes_equal)
                begin
                    wl_reg <= RW'(1);
                    wu_reg <= RW'(1);
                end
                else
                begin
                    sq_v_reg      <= {lower_reg.slope, {mrse_pkg::FRAC_BITS{1'b0}}};
                    sq_res_reg    <= '0;
                    sq_bit_reg    <= SQW'(1) << (SQW - 2);
                    sq_second_reg <= 1'b0;
                end
            end

            // Two roots in turn, one digit a cycle
            mrse_pkg::S_SQRT:
                if (sq_bit_reg[0])
                begin
                    if (!sq_second_reg)
                    begin
                        wl_reg        <= sq_res_next[RW-1:0];
                        sq_v_reg      <= {upper_knot_reg.slope, {mrse_pkg::FRAC_BITS{1'b0}}};
                        sq_res_reg    <= '0;
                        sq_bit_reg    <= SQW'(1) << (SQW - 2);
                        sq_second_reg <= 1'b1;
                    end
                    else
                        wu_reg <= sq_res_next[RW-1:0];
                end
                else
                begin
                    sq_v_reg   <= sq_v_next;
                    sq_res_reg <= sq_res_next;
                    sq_bit_reg <= sq_bit_reg >> 2;
                end

            // Load operands of the current step
            mrse_pkg::S_LAUNCH:
            begin
                acc_reg     <= '0;
                pp_reg      <= '0;
                pp_sh_reg   <= '0;
                mul_i_reg   <= '0;
                mul_j_reg   <= 1'b0;
                div_q_reg   <= '0;
                div_cnt_reg <= '0;
                case (step_reg)
                    mrse_pkg::ST_PBS:
                    begin
                        mul_a_reg <= 96'(pb_reg);   mul_b_reg <= 64'(s_sum);
                        mul_ni_reg <= 2'd0;         mul_nj_reg <= 1'b0;
                    end
                    mrse_pkg::ST_TH:
                    begin
                        mul_a_reg <= 96'(t2_reg);   mul_b_reg <= 64'(h2_reg);
                        mul_ni_reg <= 2'd0;         mul_nj_reg <= 1'b0;
                    end
                    mrse_pkg::ST_DW:
                    begin
                        mul_a_reg <= 96'(dy_reg);   mul_b_reg <= 64'(w_sel);
                        mul_ni_reg <= 2'd0;         mul_nj_reg <= 1'b0;
                    end
                    mrse_pkg::ST_X:
                    begin
                        mul_a_reg <= 96'(th_reg);   mul_b_reg <= 64'(pbs_reg);
                        mul_ni_reg <= 2'd1;         mul_nj_reg <= 1'b1;
                    end
                    mrse_pkg::ST_Y:
                    begin
                        mul_a_reg <= 96'(dw_reg);   mul_b_reg <= 64'(h2_reg - t2_reg);
                        mul_ni_reg <= 2'd1;         mul_nj_reg <= 1'b0;
                    end
                    mrse_pkg::ST_M:
                    begin
                        mul_a_reg <= 96'(dw_reg);   mul_b_reg <= 64'(h2_reg);
                        mul_ni_reg <= 2'd1;         mul_nj_reg <= 1'b0;
                    end
                    mrse_pkg::ST_R:
                    begin
                        div_rem_reg  <= 129'(xp_reg >> 1);
                        div_low_reg  <= {xp_reg[0], 47'b0};
                        div_d_reg    <= z_reg;
                        div_last_reg <= 6'd32;
                    end
                    mrse_pkg::ST_NB:
                    begin
                        mul_a_reg <= 96'(dw_reg);   mul_b_reg <= 64'(r_reg);
                        mul_ni_reg <= 2'd1;         mul_nj_reg <= 1'b1;
                    end
                    mrse_pkg::ST_BLEND:
                    begin
                        div_rem_reg  <= 129'(nb_reg >> 32);
                        div_low_reg  <= {nb_reg[31:0], 16'b0};
                        div_d_reg    <= 128'({s_sum, 32'b0});
                        div_last_reg <= 6'd31;
                    end
                    mrse_pkg::ST_MQ:
                    begin
                        div_rem_reg  <= 129'(mnum_reg >> 16);
                        div_low_reg  <= {mnum_reg[15:0], 32'b0};
                        div_d_reg    <= z_reg;
                        div_last_reg <= 6'd47;
                        if (mq_ovf)
                            res_slope <= mrse_pkg::SLOPE_MAX;
                    end
                    mrse_pkg::ST_MM:
                    begin
                        mul_a_reg <= 96'(m_reg);    mul_b_reg <= 64'(m_reg);
                        mul_ni_reg <= 2'd1;         mul_nj_reg <= 1'b1;
                    end
                    default:
                    begin
                        mul_a_reg <= mm_reg;        mul_b_reg <= 64'(pb_reg);
                        mul_ni_reg <= 2'd2;         mul_nj_reg <= 1'b0;
                    end
                endcase
            end

            // One 32x32 partial product a cycle, registered and accumulated in the next cycle
            mrse_pkg::S_MUL:
            begin
                acc_reg   <= acc_sum;
                pp_reg    <= a_chunk * b_chunk;
                pp_sh_reg <= mul_i_reg + {1'b0, mul_j_reg};
                if (mul_j_reg == mul_nj_reg)
                begin
                    mul_j_reg <= 1'b0;
                    mul_i_reg <= mul_i_reg + 2'd1;
                end
                else
                    mul_j_reg <= 1'b1;
            end

            // One quotient bit a cycle
            mrse_pkg::S_DIV:
            begin
                div_rem_reg <= div_rem_next;
                div_low_reg <= {div_low_reg[46:0], 1'b0};
                div_q_reg   <= {div_q_reg[46:0], div_ge};
                div_cnt_reg <= div_cnt_reg + 6'd1;
            end

            // Capture the step result and move on
            mrse_pkg::S_STORE:
                case (step_reg)
                    mrse_pkg::ST_PBS:
                    begin
                        pbs_reg <= acc_sum[55:0];  step_reg <= mrse_pkg::ST_TH;
                    end
                    mrse_pkg::ST_TH:
                    begin
                        th_reg <= acc_sum[63:0];   step_reg <= mrse_pkg::ST_DW;
                    end
                    mrse_pkg::ST_DW:
                    begin
                        dw_reg <= acc_sum[55:0];   step_reg <= mrse_pkg::ST_X;
                    end
                    mrse_pkg::ST_X:
                    begin
                        xp_reg <= acc_sum;         step_reg <= mrse_pkg::ST_Y;
                    end
                    mrse_pkg::ST_Y:
                    begin
                        z_reg <= xp_reg + (acc_sum << SH);
                        step_reg <= mrse_pkg::ST_M;
                    end
                    mrse_pkg::ST_M:
                    begin
                        mnum_reg <= acc_sum << SH; step_reg <= mrse_pkg::ST_R;
                    end
                    mrse_pkg::ST_R:
                    begin
                        r_reg <= div_q_reg[32:0];  step_reg <= mrse_pkg::ST_NB;
                    end
                    mrse_pkg::ST_NB:
                    begin
                        nb_reg <= acc_sum;         step_reg <= mrse_pkg::ST_BLEND;
                    end
                    mrse_pkg::ST_BLEND:
                    begin
                        res_param <= x_reg;
                        res_value <= upper_reg ? upper_knot_reg.value - div_q_reg[31:0]
                                               : lower_reg.value + div_q_reg[31:0];
                        step_reg  <= mrse_pkg::ST_MQ;
                    end
                    mrse_pkg::ST_MQ:
                    begin
                        m_reg <= div_q_reg;        step_reg <= mrse_pkg::ST_MM;
                    end
                    mrse_pkg::ST_MM:
                    begin
                        mm_reg <= acc_sum[95:0];   step_reg <= mrse_pkg::ST_P;
                    end
                    default:
                        res_slope <= (acc_sum[127:95] != '0) ? mrse_pkg::SLOPE_MAX
                                                             : $signed(acc_sum[95:64]);
                endcase

            // Hand the result to the output register
            mrse_pkg::S_FIN:
                if (fin_go)
                begin
                    status_reg    <= res_status;
                    out_param_reg <= res_param;
                    out_value_reg <= res_value;
                    out_slope_reg <= res_slope;
                end

            default:
                acc_reg <= acc_reg;
        endcase
    end

endmodule

`default_nettype wire
